FILE: rtl/core/sr_pkg.sv
// Shared constants for the scatter roughness calculator.
package sr_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned RESULT_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned GAIN_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_OFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RA_FACT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RA_MODE  = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd65536;

  localparam int unsigned RATIO_FRAC = 40;
  localparam int unsigned RATIO_W    = RATIO_FRAC + 1;
  localparam int unsigned SROOT_IN_W = RATIO_W + 1;
  localparam int unsigned SROOT_W    = SROOT_IN_W / 2;

  localparam int unsigned WAVE_W = 29;
  localparam logic [WAVE_W-1:0] WAVE_CONST = 29'd349417675;

  localparam int unsigned P1_W = SROOT_W + WAVE_W;
  localparam int unsigned T1_W = 29;
  localparam int unsigned X_W  = T1_W + GAIN_W;
  localparam int unsigned Y_W  = X_W - 16;
  localparam int unsigned XF_W = Y_W + GAIN_W;
  localparam int unsigned RES_W = XF_W - 24 + 1;

endpackage

FILE: rtl/core/sr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module sr_isqrt #(
  parameter int unsigned IN_W   = 32,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned OUT_W = IN_W / 2,
  localparam int unsigned REM_W = OUT_W + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [OUT_W-1:0]  root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [OUT_W];
  logic [REM_W-1:0]  rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [IN_W-1:0]   rad_q  [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [OUT_W-1:0]  root_in;
    logic [IN_W-1:0]   rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  cat;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      cat   = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = (cat >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (cat - trial) : cat;
        root_q[k] <= {root_in[OUT_W-2:0], ge};
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[OUT_W-1];
  assign root_o  = root_q[OUT_W-1];
  assign side_o  = side_q[OUT_W-1];

endmodule

FILE: rtl/core/sr_div.sv
// Pipelined restoring divider giving a fixed-point fraction num/den.
module sr_div #(
  parameter int unsigned NUM_W  = 16,
  parameter int unsigned FRAC   = 40,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned DEN_W = NUM_W + 1,
  localparam int unsigned Q_W   = FRAC + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [Q_W];
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    quot_q [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W:0]    cat;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    quot_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign cat     = {2'b00, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign cat     = {rem_q[k-1], 1'b0};
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      ge   = (cat >= {1'b0, den_in});
      diff = cat - {1'b0, den_in};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[Q_W-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

FILE: rtl/core/scatter_roughness_calc.sv
// Throughput: one item per cycle while the output is not stalled; set by the
// bit-per-stage root and divider pipelines.
// Any stall at the output freezes every stage; no item is lost or repeated.
// Reset clears all stage valid bits, offsets and mode to 0, gain and Ra factor to 1.0.
module scatter_roughness_calc
  import sr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = sr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned RESULT_BITS = sr_pkg::RESULT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]  diffuse_in_phase_i,
  input  logic signed [SAMPLE_BITS-1:0]  diffuse_quadrature_i,
  input  logic [SAMPLE_BITS-1:0]         specular_volts_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [RESULT_BITS-1:0]         roughness_o,
  output logic                           saturated_o,
  output logic                           no_signal_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SQ_W  = 2 * SB;
  localparam int unsigned EXT_W = 64;

  logic [SB-1:0]     diff_off_q;
  logic [SB-1:0]     spec_off_q;
  logic [GAIN_W-1:0] gain_q;
  logic [GAIN_W-1:0] ra_fact_q;
  logic              ra_mode_q;

  logic en;

  logic          v1_q;
  logic [SB-1:0] ia1_q, qa1_q, sp1_q;
  logic [SB-1:0] ia_abs, qa_abs;

  logic            v2_q;
  logic [SQ_W-1:0] sq2_q;
  logic [SB-1:0]   sp2_q;

  logic          m_valid;
  logic [SB-1:0] mag;
  logic [SB-1:0] m_spec;

  logic          v3_q;
  logic [SB-1:0] rd3_q;
  logic [SB:0]   den3_q;
  logic          nos3_q;
  logic [SB-1:0] rd, rs;

  logic               d_valid;
  logic [RATIO_W-1:0] ratio;
  logic               d_nos;

  logic               s_valid;
  logic [SROOT_W-1:0] sroot;
  logic               s_nos;

  logic            v4_q, nos4_q;
  logic [P1_W-1:0] p1_q;
  logic [P1_W:0]   p1_rnd;
  logic [T1_W-1:0] t1;

  logic           v5_q, nos5_q;
  logic [X_W-1:0] x5_q;
  logic [X_W:0]   x_rnd;
  logic [Y_W-1:0] y;

  logic                    v6_q, nos6_q;
  logic [X_W-1:0]          x6_q;
  logic [2*GAIN_W-1:0]     lo6_q;
  logic [Y_W-1:0]          hi6_q;

  logic            v7_q, nos7_q;
  logic [XF_W-1:0] xf7_q;

  logic [XF_W:0]      xf_rnd;
  logic [EXT_W-1:0]   res_ext;
  logic               sat;

  logic                   vo_q, sat_q, nos_q;
  logic [RESULT_BITS-1:0] rough_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_off_q <= '0;
      spec_off_q <= '0;
      gain_q     <= GAIN_ONE;
      ra_fact_q  <= GAIN_ONE;
      ra_mode_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DIFF_OFF: diff_off_q <= cfg_data_i[SB-1:0];
        CFG_SPEC_OFF: spec_off_q <= cfg_data_i[SB-1:0];
        CFG_GAIN:     gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_RA_FACT:  ra_fact_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_RA_MODE:  ra_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // absolute values
  assign ia_abs = diffuse_in_phase_i[SB-1] ? (~diffuse_in_phase_i + 1'b1) : diffuse_in_phase_i;
  assign qa_abs = diffuse_quadrature_i[SB-1] ?
                  (~diffuse_quadrature_i + 1'b1) : diffuse_quadrature_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= m_valid;
      v4_q <= s_valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      vo_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ia1_q <= ia_abs;
      qa1_q <= qa_abs;
      sp1_q <= specular_volts_i;
      sq2_q <= (SQ_W'(ia1_q) * SQ_W'(ia1_q)) + (SQ_W'(qa1_q) * SQ_W'(qa1_q));
      sp2_q <= sp1_q;
    end
  end

  sr_isqrt #(
    .IN_W   (SQ_W),
    .SIDE_W (SB)
  ) u_mag_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (sq2_q),
    .side_i  (sp2_q),
    .valid_o (m_valid),
    .root_o  (mag),
    .side_o  (m_spec)
  );

  // drop offsets, clamp at zero
  assign rd = (mag > diff_off_q) ? (mag - diff_off_q) : '0;
  assign rs = (m_spec > spec_off_q) ? (m_spec - spec_off_q) : '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd3_q  <= rd;
      den3_q <= {1'b0, rd} + {1'b0, rs};
      nos3_q <= (rd == '0) && (rs == '0);
    end
  end

  sr_div #(
    .NUM_W  (SB),
    .FRAC   (RATIO_FRAC),
    .SIDE_W (1)
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (rd3_q),
    .den_i   (den3_q),
    .side_i  (nos3_q),
    .valid_o (d_valid),
    .quot_o  (ratio),
    .side_o  (d_nos)
  );

  sr_isqrt #(
    .IN_W   (SROOT_IN_W),
    .SIDE_W (1)
  ) u_ratio_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .rad_i   ({1'b0, ratio}),
    .side_i  (d_nos),
    .valid_o (s_valid),
    .root_o  (sroot),
    .side_o  (s_nos)
  );

  assign p1_rnd = {1'b0, p1_q} + (P1_W+1)'(1 << 19);
  assign t1     = p1_rnd[20 +: T1_W];
  assign x_rnd  = {1'b0, x5_q} + (X_W+1)'(1 << 15);
  assign y      = x_rnd[16 +: Y_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= P1_W'(sroot) * P1_W'(WAVE_CONST);
      nos4_q <= s_nos;
      x5_q   <= X_W'(t1) * X_W'(gain_q);
      nos5_q <= nos4_q;
      x6_q   <= x5_q;
      lo6_q  <= y[GAIN_W-1:0] * ra_fact_q;
      hi6_q  <= Y_W'(y[Y_W-1:GAIN_W]) * Y_W'(ra_fact_q);
      nos6_q <= nos5_q;
      xf7_q  <= ra_mode_q ? ({hi6_q, {GAIN_W{1'b0}}} + XF_W'(lo6_q)) : XF_W'(x6_q);
      nos7_q <= nos6_q;
    end
  end

  assign xf_rnd  = {1'b0, xf7_q} + (XF_W+1)'(1 << 23);
  assign res_ext = EXT_W'(xf_rnd[XF_W:24]);
  assign sat     = (res_ext >> RESULT_BITS) != '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nos_q   <= nos7_q;
      sat_q   <= !nos7_q && sat;
      rough_q <= nos7_q ? '0 : (sat ? '1 : res_ext[RESULT_BITS-1:0]);
    end
  end

  assign out_valid_o = vo_q;
  assign roughness_o = rough_q;
  assign saturated_o = sat_q;
  assign no_signal_o = nos_q;

  a_nos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_signal_o |-> roughness_o == '0 && !saturated_o)
    else $error("no-signal item carries a nonzero result");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> roughness_o == '1)
    else $error("saturated item not at maximum");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline is stalled");

endmodule
